// ===== hw/rtl/rrs_pkg.sv =====
// Package for the region-of-interest RGB statistics block.
// Holds the beat payload types, lane status type and register codes.
// No dependencies; used by the lane, the top level, the checker and the testbench.
package rrs_pkg;

  localparam int NUM_CH_MAX = 3;
  localparam logic [24:0] COUNT_MAX = 25'h1FF_FFFF;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_ROI_LEFT   = 2'd0;
  localparam logic [1:0] REG_ROI_TOP    = 2'd1;
  localparam logic [1:0] REG_ROI_RIGHT  = 2'd2;
  localparam logic [1:0] REG_ROI_BOTTOM = 2'd3;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        end_of_frame;
  } pixel_t;

  typedef struct packed {
    logic [1:0]  channel;
    logic [24:0] pixel_count;
    logic [7:0]  min_value;
    logic [11:0] min_col;
    logic [11:0] min_row;
    logic [7:0]  max_value;
    logic [11:0] max_col;
    logic [11:0] max_row;
    logic [7:0]  value_range;
    logic [15:0] mean_q8;
    logic [21:0] variance_q8;
    logic        last_result;
  } result_t;

  // Statistics kept by one channel lane. Positions hold the row in the
  // upper twelve bits and the column in the lower twelve.
  typedef struct packed {
    logic [7:0]  min_value;
    logic [7:0]  max_value;
    logic [23:0] min_pos;
    logic [23:0] max_pos;
    logic [32:0] sum;
    logic [40:0] sumsq;
  } lane_stats_t;

endpackage

// ===== hw/rtl/rrs_stream_if.sv =====
// Valid/ready stream interface used by the pixel and result channels.
// Payload type is a parameter; types come from rrs_pkg.
interface rrs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rrs_lane.sv =====
// One channel lane: running minimum, maximum, their first positions,
// sum and sum of squares. Uses rrs_pkg::lane_stats_t.
module rrs_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          value,
  input  logic                hit,
  input  logic                first,
  input  logic [23:0]         pos,
  input  logic                clear,
  output rrs_pkg::lane_stats_t stats
);

  rrs_pkg::lane_stats_t st_r;
  logic [15:0] sq;

  assign sq = {8'd0, value} * {8'd0, value};

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      st_r <= '0;
    end else if (hit) begin
      if (first) begin
        st_r.min_value <= value;
        st_r.max_value <= value;
        st_r.min_pos   <= pos;
        st_r.max_pos   <= pos;
      end else if (value < st_r.min_value) begin
        st_r.min_value <= value;
        st_r.min_pos   <= pos;
      end else if (value > st_r.max_value) begin
        st_r.max_value <= value;
        st_r.max_pos   <= pos;
      end
      st_r.sum   <= st_r.sum + 33'(value);
      st_r.sumsq <= st_r.sumsq + 41'(sq);
    end
  end

  assign stats = st_r;

endmodule

// ===== hw/rtl/rrs_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle.
// Self-contained; no package types needed.
module rrs_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [40:0] a,
  input  logic [32:0] b,
  output logic        done,
  output logic [73:0] product
);

  logic [73:0] acc_r;
  logic [73:0] mcand_r;
  logic [32:0] mplier_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        acc_r    <= '0;
        mcand_r  <= 74'(a);
        mplier_r <= b;
      end else if (busy_r) begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= {mcand_r[72:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[32:1]};
        cnt_r    <= cnt_r + 6'd1;
        if (cnt_r == 6'd32) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== hw/rtl/rrs_div.sv =====
// Restoring divider, one quotient bit per cycle, up to 22 quotient bits.
// The caller supplies the upper numerator part, already below the divisor.
module rrs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [50:0] rem_init,
  input  logic [21:0] low_bits,
  input  logic [49:0] divisor,
  input  logic [4:0]  steps,
  output logic        done,
  output logic [21:0] quotient
);

  logic [50:0] rem_r;
  logic [21:0] low_r;
  logic [21:0] quo_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [50:0] trial;
  logic [50:0] den;

  assign den   = {1'b0, divisor};
  assign trial = {rem_r[49:0], low_r[21]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= rem_init;
        low_r  <= low_bits;
        quo_r  <= '0;
        cnt_r  <= steps;
      end else if (busy_r) begin
        if (trial >= den) begin
          rem_r <= trial - den;
          quo_r <= {quo_r[20:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[20:0], 1'b0};
        end
        low_r <= {low_r[20:0], 1'b0};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/roi_rgb_statistics.sv =====
// Region-of-interest RGB statistics, top level.
// Uses rrs_pkg, rrs_stream_if, rrs_lane, rrs_mul and rrs_div.
//
// Usage: pixels arrive as beats on in_ch in raster order, each with its
// column, row, three channel values and an end-of-frame flag. Pixels that
// fall inside the inclusive rectangle held in the APB registers (and inside
// MAX_WIDTH x MAX_HEIGHT) are counted. One lane per channel tracks the
// minimum and maximum with their first position, the sum and the sum of
// squares, so an ordinary pixel beat is taken every cycle while idle.
// When the end-of-frame beat is accepted, in_ch.ready drops and a shared
// sequencer walks the lanes one at a time: three 33-step shift-add
// multiplies (n*sumsq, sum*sum, n*n), each with start and handoff,
// then a 16-step divide for the mean and a 22-step divide for the
// variance. Each lane gives one result beat, in channel order.
// Each result beat sits in an output register on out_ch until it is taken;
// a stalled receiver simply holds the block in that state. After the last
// beat (last_result high) the statistics are cleared and in_ch.ready
// returns. Registers may be written over APB while the block is idle;
// pready is always high. Reset restores the full-frame rectangle and
// clears all statistics.
module roi_rgb_statistics #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int CHANNELS   = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  rrs_stream_if.sink   in_ch,
  rrs_stream_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NCH = (CHANNELS < 1) ? 1 : ((CHANNELS > 3) ? 3 : CHANNELS);
  localparam logic [1:0] LAST_CH = 2'(NCH - 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL_NQ   = 3'd1;
  localparam logic [2:0] ST_MUL_SS   = 3'd2;
  localparam logic [2:0] ST_MUL_NN   = 3'd3;
  localparam logic [2:0] ST_DIV_MEAN = 3'd4;
  localparam logic [2:0] ST_DIV_VAR  = 3'd5;
  localparam logic [2:0] ST_OUT      = 3'd6;

  // Configuration registers.
  logic [11:0] roi_left_r, roi_top_r, roi_right_r, roi_bottom_r;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roi_left_r   <= 12'd0;
      roi_top_r    <= 12'd0;
      roi_right_r  <= 12'd4095;
      roi_bottom_r <= 12'd4095;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        rrs_pkg::REG_ROI_LEFT:   roi_left_r   <= pwdata[11:0];
        rrs_pkg::REG_ROI_TOP:    roi_top_r    <= pwdata[11:0];
        rrs_pkg::REG_ROI_RIGHT:  roi_right_r  <= pwdata[11:0];
        rrs_pkg::REG_ROI_BOTTOM: roi_bottom_r <= pwdata[11:0];
        default:                 roi_left_r   <= roi_left_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      rrs_pkg::REG_ROI_LEFT:   prdata = {20'd0, roi_left_r};
      rrs_pkg::REG_ROI_TOP:    prdata = {20'd0, roi_top_r};
      rrs_pkg::REG_ROI_RIGHT:  prdata = {20'd0, roi_right_r};
      rrs_pkg::REG_ROI_BOTTOM: prdata = {20'd0, roi_bottom_r};
      default:                 prdata = 32'd0;
    endcase
  end

  // Input side: region test and pixel count.
  logic [2:0]  state_r, state_nxt;
  logic [24:0] count_r;
  logic        in_fire, in_roi, hit, clear_stats;
  rrs_pkg::pixel_t px;

  assign px      = in_ch.data;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_roi  = (px.pixel_x >= roi_left_r) && (px.pixel_x <= roi_right_r) &&
                   (px.pixel_y >= roi_top_r) && (px.pixel_y <= roi_bottom_r) &&
                   (32'(px.pixel_x) < MAX_WIDTH) && (32'(px.pixel_y) < MAX_HEIGHT) &&
                   (count_r < rrs_pkg::COUNT_MAX);
  assign hit     = in_fire && in_roi;

  always_ff @(posedge clk) begin
    if (!rst_n || clear_stats) begin
      count_r <= '0;
    end else if (hit) begin
      count_r <= count_r + 25'd1;
    end
  end

  // Channel lanes; unused slots read as zero.
  rrs_pkg::lane_stats_t lane_st [rrs_pkg::NUM_CH_MAX];
  logic [7:0] lane_val [rrs_pkg::NUM_CH_MAX];

  assign lane_val[0] = px.red;
  assign lane_val[1] = px.green;
  assign lane_val[2] = px.blue;

  for (genvar c = 0; c < rrs_pkg::NUM_CH_MAX; c++) begin : g_lane
    if (c < NCH) begin : g_on
      rrs_lane u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .value (lane_val[c]),
        .hit   (hit),
        .first (count_r == 25'd0),
        .pos   ({px.pixel_y, px.pixel_x}),
        .clear (clear_stats),
        .stats (lane_st[c])
      );
    end else begin : g_off
      assign lane_st[c] = '0;
    end
  end

  // Merging sequencer: one channel at a time through the shared units.
  logic [1:0]  chan_r;
  logic        mul_start_r, div_start_r;
  logic [65:0] p1_r;
  logic [65:0] d_r;
  logic [49:0] nn_r;
  logic [15:0] mean_r;
  logic        out_valid_r;
  rrs_pkg::result_t out_data_r;
  rrs_pkg::lane_stats_t cur;

  logic [40:0] mul_a;
  logic [32:0] mul_b;
  logic        mul_done;
  logic [73:0] mul_p;
  logic [50:0] div_rem;
  logic [21:0] div_low;
  logic [49:0] div_den;
  logic [4:0]  div_steps;
  logic        div_done;
  logic [21:0] div_q;
  logic        out_fire;
  logic        empty;

  assign cur      = lane_st[chan_r];
  assign out_fire = out_valid_r && out_ch.ready;
  assign empty    = (count_r == 25'd0);
  assign clear_stats = out_fire && (chan_r == LAST_CH);

  always_comb begin
    unique case (state_r)
      ST_MUL_SS: begin
        mul_a = 41'(cur.sum);
        mul_b = cur.sum;
      end
      ST_MUL_NN: begin
        mul_a = 41'(count_r);
        mul_b = 33'(count_r);
      end
      default: begin
        mul_a = cur.sumsq;
        mul_b = 33'(count_r);
      end
    endcase
  end

  always_comb begin
    if (state_r == ST_DIV_VAR) begin
      div_rem   = 51'(d_r >> 14);
      div_low   = {d_r[13:0], 8'd0};
      div_den   = nn_r;
      div_steps = 5'd22;
    end else begin
      div_rem   = 51'(cur.sum >> 8);
      div_low   = {cur.sum[7:0], 14'd0};
      div_den   = 50'(count_r);
      div_steps = 5'd16;
    end
  end

  rrs_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  rrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .rem_init (div_rem),
    .low_bits (div_low),
    .divisor  (div_den),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_fire && px.end_of_frame) state_nxt = ST_MUL_NQ;
      ST_MUL_NQ:   if (mul_done) state_nxt = ST_MUL_SS;
      ST_MUL_SS:   if (mul_done) state_nxt = ST_MUL_NN;
      ST_MUL_NN:   if (mul_done) state_nxt = ST_DIV_MEAN;
      ST_DIV_MEAN: if (div_done) state_nxt = ST_DIV_VAR;
      ST_DIV_VAR:  if (div_done) state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_fire) begin
          state_nxt = (chan_r == LAST_CH) ? ST_IDLE : ST_MUL_NQ;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chan_r      <= 2'd0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mul_start_r <= (state_nxt != state_r) &&
                     (state_nxt == ST_MUL_NQ || state_nxt == ST_MUL_SS ||
                      state_nxt == ST_MUL_NN);
      div_start_r <= (state_nxt != state_r) &&
                     (state_nxt == ST_DIV_MEAN || state_nxt == ST_DIV_VAR);
      if (state_r == ST_IDLE && state_nxt == ST_MUL_NQ) begin
        chan_r <= 2'd0;
      end
      if (out_fire) begin
        out_valid_r <= 1'b0;
        chan_r      <= (chan_r == LAST_CH) ? 2'd0 : chan_r + 2'd1;
      end
      if (state_r == ST_DIV_VAR && div_done) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Datapath registers between the shared units.
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL_NQ && mul_done) begin
      p1_r <= mul_p[65:0];
    end
    if (state_r == ST_MUL_SS && mul_done) begin
      d_r <= (p1_r >= mul_p[65:0]) ? (p1_r - mul_p[65:0]) : 66'd0;
    end
    if (state_r == ST_MUL_NN && mul_done) begin
      nn_r <= mul_p[49:0];
    end
    if (state_r == ST_DIV_MEAN && div_done) begin
      mean_r <= empty ? 16'd0 : div_q[15:0];
    end
    if (state_r == ST_DIV_VAR && div_done) begin
      out_data_r.channel     <= chan_r;
      out_data_r.pixel_count <= count_r;
      out_data_r.min_value   <= cur.min_value;
      out_data_r.min_col     <= cur.min_pos[11:0];
      out_data_r.min_row     <= cur.min_pos[23:12];
      out_data_r.max_value   <= cur.max_value;
      out_data_r.max_col     <= cur.max_pos[11:0];
      out_data_r.max_row     <= cur.max_pos[23:12];
      out_data_r.value_range <= cur.max_value - cur.min_value;
      out_data_r.mean_q8     <= mean_r;
      out_data_r.variance_q8 <= empty ? 22'd0 : div_q;
      out_data_r.last_result <= (chan_r == LAST_CH);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ===== hw/rtl/rrs_checker.sv =====
// Port-level checker for roi_rgb_statistics, attached by bind.
// Uses rrs_pkg result fields as seen on the top level's ports.
module rrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  channel,
  input logic [24:0] pixel_count,
  input logic [7:0]  min_value,
  input logic [7:0]  max_value,
  input logic [7:0]  value_range,
  input logic [15:0] mean_q8,
  input logic [21:0] variance_q8,
  input logic        pready
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(mean_q8))
    else $error("result beat changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("pixels accepted while results pending");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> value_range == 8'(max_value - min_value) && min_value <= max_value)
    else $error("range does not match min and max");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pixel_count == 25'd0 |-> mean_q8 == 16'd0 && variance_q8 == 22'd0)
    else $error("empty region gave nonzero mean or variance");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pready && (channel != 2'd3 || !out_valid))
    else $error("bad channel or pready low");

endmodule

bind roi_rgb_statistics rrs_checker u_rrs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .channel     (out_ch.data.channel),
  .pixel_count (out_ch.data.pixel_count),
  .min_value   (out_ch.data.min_value),
  .max_value   (out_ch.data.max_value),
  .value_range (out_ch.data.value_range),
  .mean_q8     (out_ch.data.mean_q8),
  .variance_q8 (out_ch.data.variance_q8),
  .pready      (pready)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for roi_rgb_statistics: raster-order pixel frames
// against a cycle-free model of the region statistics. Depends on rrs_pkg,
// rrs_stream_if and the roi_rgb_statistics RTL.
module tb_top;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int FRAME_LATENCY = 600;
  localparam int TARGET_ITEMS  = 230;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rrs_stream_if #(.T(rrs_pkg::pixel_t))  pix_if ();
  rrs_stream_if #(.T(rrs_pkg::result_t)) stat_if ();

  roi_rgb_statistics u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (pix_if),
    .out_ch  (stat_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // The clock toggles through two delays, giving a period of ten units.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Pixel beats waiting to be offered, and the statistics expected back.
  rrs_pkg::pixel_t  pending_pixels[$];
  rrs_pkg::result_t expected_stats[$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned items_queued;
  bit          quiet;      // No idling at all in the closing part of the run.
  bit          long_hold;  // Receiver holds off for a long stretch.
  int          phase;

  // Region registers as the model sees them.
  logic [11:0] roi_l, roi_t, roi_r, roi_b;

  // Running statistics of the frame in progress, one entry per channel.
  logic [24:0] px_count;
  logic [7:0]  lo_val[3];
  logic [7:0]  hi_val[3];
  logic [23:0] lo_pos[3];
  logic [23:0] hi_pos[3];
  logic [32:0] ch_sum[3];
  logic [40:0] ch_sumsq[3];

  function automatic void clear_frame_stats();
    px_count = '0;
    for (int c = 0; c < 3; c++) begin
      lo_val[c] = '0; hi_val[c] = '0; lo_pos[c] = '0; hi_pos[c] = '0;
      ch_sum[c] = '0; ch_sumsq[c] = '0;
    end
  endfunction

  // Folds one accepted pixel into the frame statistics. On the end-of-frame
  // pixel it also queues the three per-channel results and starts afresh.
  function automatic void accumulate_pixel(rrs_pkg::pixel_t p);
    logic [7:0]   v[3];
    logic [23:0]  pos;
    logic [127:0] n, s, q, num, den;
    rrs_pkg::result_t r;
    v[0] = p.red; v[1] = p.green; v[2] = p.blue;
    pos = {p.pixel_y, p.pixel_x};
    if (p.pixel_x >= roi_l && p.pixel_x <= roi_r && p.pixel_y >= roi_t &&
        p.pixel_y <= roi_b && px_count < rrs_pkg::COUNT_MAX) begin
      for (int c = 0; c < 3; c++) begin
        // The first counted pixel seeds both extremes; later ties keep the
        // earlier position because only strict comparisons replace them.
        if (px_count == 0) begin
          lo_val[c] = v[c]; hi_val[c] = v[c]; lo_pos[c] = pos; hi_pos[c] = pos;
        end else if (v[c] < lo_val[c]) begin
          lo_val[c] = v[c]; lo_pos[c] = pos;
        end else if (v[c] > hi_val[c]) begin
          hi_val[c] = v[c]; hi_pos[c] = pos;
        end
        ch_sum[c]   += 33'(v[c]);
        ch_sumsq[c] += 41'(v[c]) * 41'(v[c]);
      end
      px_count++;
    end
    if (!p.end_of_frame) return;
    for (int c = 0; c < 3; c++) begin
      r = '0;
      r.channel     = 2'(c);
      r.pixel_count = px_count;
      r.min_value   = lo_val[c];
      r.min_col     = lo_pos[c][11:0];
      r.min_row     = lo_pos[c][23:12];
      r.max_value   = hi_val[c];
      r.max_col     = hi_pos[c][11:0];
      r.max_row     = hi_pos[c][23:12];
      r.value_range = hi_val[c] - lo_val[c];
      r.last_result = (c == 2);
      if (px_count != 0) begin
        n = 128'(px_count); s = 128'(ch_sum[c]); q = 128'(ch_sumsq[c]);
        r.mean_q8 = 16'((s << 8) / n);
        // One-pass variance: (n*sumsq - sum^2) / n^2, never below zero.
        num = (n * q >= s * s) ? ((n * q - s * s) << 8) : '0;
        den = n * n;
        r.variance_q8 = 22'(num / den);
      end
      expected_stats.push_back(r);
    end
    clear_frame_stats();
  endfunction

  // Compares one result beat with the oldest expectation, field by field.
  function automatic void check_result(rrs_pkg::result_t got);
    rrs_pkg::result_t exp;
    string   bad;
    if (expected_stats.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat %p", got);
      return;
    end
    exp = expected_stats.pop_front();
    bad = "";
    if (got.channel     !== exp.channel)     bad = {bad, " channel"};
    if (got.pixel_count !== exp.pixel_count) bad = {bad, " pixel_count"};
    if (got.min_value   !== exp.min_value)   bad = {bad, " min_value"};
    if (got.min_col     !== exp.min_col)     bad = {bad, " min_col"};
    if (got.min_row     !== exp.min_row)     bad = {bad, " min_row"};
    if (got.max_value   !== exp.max_value)   bad = {bad, " max_value"};
    if (got.max_col     !== exp.max_col)     bad = {bad, " max_col"};
    if (got.max_row     !== exp.max_row)     bad = {bad, " max_row"};
    if (got.value_range !== exp.value_range) bad = {bad, " value_range"};
    if (got.mean_q8     !== exp.mean_q8)     bad = {bad, " mean_q8"};
    if (got.variance_q8 !== exp.variance_q8) bad = {bad, " variance_q8"};
    if (got.last_result !== exp.last_result) bad = {bad, " last_result"};
    if (bad != "") begin
      errors++;
      if (errors <= 10) $display("mismatch in%s\n  expected %p\n  actual   %p", bad, exp, got);
    end
  endfunction

  // Monitor: every accepted pixel beat updates the model, every accepted
  // result beat is checked. Both are sampled at the rising edge.
  bit pix_taken;
  always @(posedge clk) begin
    cycles++;
    pix_taken <= pix_if.valid && pix_if.ready;
    if (rst_n && pix_if.valid && pix_if.ready) accumulate_pixel(pix_if.data);
    if (rst_n && stat_if.valid && stat_if.ready) check_result(stat_if.data);
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Driver: offers the next pending pixel at the falling edge, with random
  // bursts of idle cycles between beats.
  int send_gap;
  always @(negedge clk) begin
    logic            nv;
    rrs_pkg::pixel_t nd;
    nd = pix_if.data;
    nv = pix_if.valid;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!pix_if.valid || pix_taken) begin
      if (send_gap > 0 && !quiet) begin
        send_gap--;
        nv = 1'b0;
      end else if (pending_pixels.size() != 0) begin
        nd = pending_pixels.pop_front();
        nv = 1'b1;
        if (!quiet && $urandom_range(0, 6) == 0) send_gap = $urandom_range(1, 19);
      end else begin
        nv = 1'b0;
      end
    end
    pix_if.valid <= nv;
    pix_if.data  <= nd;
  end

  // Receiver: random stall bursts, plus the long hold-off when requested.
  int stall_left;
  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 19);
    stat_if.ready <= rst_n && !long_hold && (quiet || stall_left == 0);
  end

  // Long receiver hold-off during the busy second phase, timed in cycles here.
  initial begin
    long_hold = 1'b0;
    wait (phase == 1);
    repeat (30) @(negedge clk);
    long_hold = 1'b1;
    repeat (700) @(negedge clk);
    long_hold = 1'b0;
  end

  // One APB write: setup cycle then access cycle. The model register moves
  // along with it.
  task automatic write_reg(logic [1:0] idx, logic [11:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      rrs_pkg::REG_ROI_LEFT:   roi_l = value;
      rrs_pkg::REG_ROI_TOP:    roi_t = value;
      rrs_pkg::REG_ROI_RIGHT:  roi_r = value;
      default:                 roi_b = value;
    endcase
  endtask

  task automatic set_region(int l, int t, int r, int b);
    write_reg(rrs_pkg::REG_ROI_LEFT, 12'(l));
    write_reg(rrs_pkg::REG_ROI_TOP, 12'(t));
    write_reg(rrs_pkg::REG_ROI_RIGHT, 12'(r));
    write_reg(rrs_pkg::REG_ROI_BOTTOM, 12'(b));
  endtask

  function automatic void queue_pixel(int x, int y, int r, int g, int b, bit eof);
    rrs_pkg::pixel_t p;
    p.pixel_x = 12'(x); p.pixel_y = 12'(y);
    p.red = 8'(r); p.green = 8'(g); p.blue = 8'(b);
    p.end_of_frame = eof;
    pending_pixels.push_back(p);
    items_queued++;
  endfunction

  function automatic int clamp12(int v);
    return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
  endfunction

  function automatic int pick_value(int mode, int base);
    case (mode)
      0:       return $urandom_range(0, 255);
      1:       return base;
      2:       return $urandom_range(0, 1) ? 255 : 0;
      default: return clamp12(base + $urandom_range(0, 3)) & 8'hFF;
    endcase
  endfunction

  // A raster-order frame that straddles the region edges, with a random
  // value style: random, flat (all ties), extremes only or narrow spread.
  function automatic void queue_frame();
    int x0, y0, w, h, mode, base;
    x0 = clamp12(int'(roi_l) - int'($urandom_range(0, 2)));
    y0 = clamp12(int'(roi_t) - int'($urandom_range(0, 2)));
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 4);
    mode = $urandom_range(0, 3);
    base = $urandom_range(0, 255);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        queue_pixel(clamp12(x0 + x), clamp12(y0 + y), pick_value(mode, base),
                    pick_value(mode, base), pick_value(mode, base),
                    (x == w - 1) && (y == h - 1));
  endfunction

  // Noise: coordinates anywhere, ending with an end-of-frame pixel.
  function automatic void queue_noise(int len);
    for (int i = 0; i < len; i++)
      queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255), i == len - 1);
  endfunction

  // Holds the sender until every queued pixel is taken and every expected
  // result has come back, then lets the end-of-frame work settle.
  task automatic drain();
    while (pending_pixels.size() != 0 || pix_if.valid || expected_stats.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic random_frames(int budget);
    int stop_at;
    stop_at = items_queued + budget;
    while (items_queued < stop_at) begin
      if ($urandom_range(0, 4) == 0) queue_noise($urandom_range(1, 6));
      else queue_frame();
    end
  endtask

  initial begin
    int l, t;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    pix_if.valid = 1'b0; pix_if.data = '0;
    stat_if.ready = 1'b0;
    errors = 0; cycles = 0; items_queued = 0; quiet = 1'b0; phase = 0;
    send_gap = 0; stall_left = 0;
    roi_l = 12'd0; roi_t = 12'd0; roi_r = 12'd4095; roi_b = 12'd4095;
    clear_frame_stats();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: full-frame region, field extremes, ties and empty frames.
    set_region(0, 0, 4095, 4095);
    queue_pixel(0, 0, 0, 255, 128, 1'b1);              // single-pixel frame
    queue_pixel(4095, 4095, 255, 0, 255, 1'b0);
    queue_pixel(4095, 0, 255, 0, 0, 1'b0);             // ties stay at first spot
    queue_pixel(0, 4095, 0, 255, 255, 1'b0);
    queue_pixel(2730, 1365, 170, 85, 85, 1'b1);
    queue_pixel(1365, 2730, 85, 170, 170, 1'b0);
    queue_pixel(1, 1, 85, 170, 170, 1'b1);             // flat frame, variance 0
    drain();
    set_region(100, 50, 102, 51);
    queue_pixel(99, 50, 1, 2, 3, 1'b1);                // empty region result
    queue_pixel(103, 52, 9, 9, 9, 1'b1);
    for (int y = 50; y <= 51; y++)
      for (int x = 99; x <= 103; x++)
        queue_pixel(x, y, (x * 37) & 8'hFF, y, 255 - x, (x == 103) && (y == 51));
    drain();

    // Random frames on a small region, with the long receiver hold-off.
    phase = 1;
    random_frames(70);
    drain();

    // Single-pixel region at the far corner.
    phase = 2;
    set_region(4095, 4095, 4095, 4095);
    queue_pixel(4095, 4095, 200, 100, 50, 1'b1);
    queue_pixel(4094, 4095, 1, 1, 1, 1'b1);
    random_frames(25);
    drain();

    // Inverted rectangle: nothing is ever counted.
    phase = 3;
    set_region(30, 40, 20, 10);
    random_frames(25);
    drain();

    // A random region.
    phase = 4;
    l = $urandom_range(0, 4000);
    t = $urandom_range(0, 4000);
    set_region(l, t, l + $urandom_range(0, 95), t + $urandom_range(0, 95));
    random_frames(40);
    drain();

    // Closing part without any idling, back on the full frame.
    phase = 5;
    quiet = 1'b1;
    set_region(0, 0, 4095, 4095);
    random_frames(TARGET_ITEMS - items_queued > 20 ? TARGET_ITEMS - items_queued : 20);
    drain();
    repeat (FRAME_LATENCY) @(posedge clk);

    if (errors == 0 && expected_stats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
